FILE: hdl/dpt_pkg.sv
// Package for the delivery persistence tracker: phase and command codes,
// table sizing, and the state and result structs. No dependencies.
`default_nettype none

package dpt_pkg;

    // Request table
    localparam int MAX_REQUESTS = 16;
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    // Fixed field widths
    localparam int CMD_W   = 3;
    localparam int RID_W   = 4;
    localparam int PHASE_W = 4;
    localparam int OUTS_W  = 5;

    typedef enum logic [PHASE_W-1:0] {
        PH_CREATING  = 4'd0,
        PH_TRANSIENT = 4'd1,
        PH_NEW       = 4'd2,
        PH_CWN       = 4'd3,
        PH_SAVING    = 4'd4,
        PH_SAVED     = 4'd5,
        PH_UPDATING  = 4'd6,
        PH_CWS       = 4'd7,
        PH_CHANGED   = 4'd8,
        PH_COMPLETE  = 4'd9,
        PH_DELETING  = 4'd10,
        PH_TERMINAL  = 4'd11
    } phase_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ROUTE     = 3'd0,
        CMD_DISPATCH  = 3'd1,
        CMD_COMPLETE  = 3'd2,
        CMD_FRONT     = 3'd3,
        CMD_PERSISTED = 3'd4,
        CMD_RECONNECT = 3'd5
    } cmd_t;

    typedef struct packed {
        phase_t                  phase;
        logic [CNT_W-1:0]        total;
        logic [CNT_W-1:0]        completed;
        logic [MAX_REQUESTS-1:0] pending;
        logic                    safe;
        logic                    has_manager;
    } dpt_state_t;

    typedef struct packed {
        logic                    error;
        logic [OUTS_W-1:0]       outstanding;
        logic                    release_slip;
        logic                    safe;
        logic                    remove_start;
        logic                    update_start;
        logic                    store_start;
        logic                    queue_done;
        logic                    enqueue_persist;
        logic                    request_recorded;
        logic [RID_W-1:0]        new_request_id;
        phase_t                  slip_state;
    } dpt_result_t;

endpackage

`default_nettype wire

FILE: hdl/delivery_persistence_tracker.sv
// Delivery persistence tracker: top level with stream ports, tracker state
// and result register. Depends on dpt_pkg and dpt_step.
//
// An accepted request's result is registered and appears on m_axis in the next cycle.
// Throughput: one request per cycle; s_axis_tready stays high while the
//   result register is empty or being drained in the same cycle.
// Reset (rst_n low, async): phase creating, counters and pending map clear,
//   safe and manager flags clear, persistence_present 0, no result pending.
`default_nettype none

module delivery_persistence_tracker
    import dpt_pkg::*;
(
    input  wire  logic        clk,
    input  wire  logic        rst_n,

    // Configuration: persistence_present
    input  wire  logic        cfg_wr_en,
    input  wire  logic        cfg_wr_data,

    // Request stream
    input  wire  logic        s_axis_tvalid,
    output logic              s_axis_tready,
    // [0] chan_reliable, [1] event_reliable_valid, [2] event_reliable_value,
    // [3] supplier_shut_down, [7:4] done_id
    input  wire  logic [7:0]  s_axis_tdata,
    // [2:0] command
    input  wire  logic [2:0]  s_axis_tuser,

    // Result stream
    output logic              m_axis_tvalid,
    input  wire  logic        m_axis_tready,
    // [3:0] slip_state, [7:4] new_request_id, [8] request_recorded,
    // [9] enqueue_persist, [10] queue_done, [11] store_start,
    // [12] update_start, [13] remove_start, [14] safe, [15] release_slip,
    // [20:16] outstanding, [21] error, [23:22] zero
    output logic [23:0]       m_axis_tdata
);

    logic        persist_reg;
    dpt_state_t  state_reg;
    dpt_state_t  state_next;
    dpt_result_t step_res;
    dpt_result_t res_reg;
    logic        m_valid_reg;
    logic        accept;

    // Result register frees up when it is empty or drained this cycle.
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    dpt_step u_step (
        .cur                  (state_reg),
        .command              (s_axis_tuser),
        .chan_reliable        (s_axis_tdata[0]),
        .event_reliable_valid (s_axis_tdata[1]),
        .event_reliable_value (s_axis_tdata[2]),
        .supplier_shut_down   (s_axis_tdata[3]),
        .done_id              (s_axis_tdata[7:4]),
        .persistence_present  (persist_reg),
        .nxt                  (state_next),
        .res                  (step_res)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            persist_reg <= 1'b0;
        else if (cfg_wr_en)
            persist_reg <= cfg_wr_data;
    end

    // Tracker state advances on every accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= PH_CREATING;
            state_reg.total       <= '0;
            state_reg.completed   <= '0;
            state_reg.pending     <= '0;
            state_reg.safe        <= 1'b0;
            state_reg.has_manager <= 1'b0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (accept)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= step_res;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, res_reg};

endmodule

`default_nettype wire

FILE: hdl/dpt_step.sv
// Next-state and result logic for one tracker request.
// Depends on dpt_pkg.
`default_nettype none

module dpt_step
    import dpt_pkg::*;
(
    input  wire  dpt_state_t         cur,
    input  wire  logic [CMD_W-1:0]   command,
    input  wire  logic               chan_reliable,
    input  wire  logic               event_reliable_valid,
    input  wire  logic               event_reliable_value,
    input  wire  logic               supplier_shut_down,
    input  wire  logic [RID_W-1:0]   done_id,
    input  wire  logic               persistence_present,
    output dpt_state_t               nxt,
    output dpt_result_t              res
);

    logic                 full;
    logic                 rid_ok;
    logic [CNT_W-1:0]     total_inc;
    logic [CNT_W-1:0]     comp_inc;
    logic [IDX_W-1:0]     rec_idx;
    logic [IDX_W-1:0]     rid_idx;

    assign full      = 32'(cur.total) >= 32'(MAX_REQUESTS);
    assign total_inc = cur.total + CNT_W'(1);
    assign comp_inc  = cur.completed + CNT_W'(1);
    assign rec_idx   = cur.total[IDX_W-1:0];
    assign rid_idx   = IDX_W'(done_id);
    assign rid_ok    = (32'(done_id) < 32'(cur.total))
                    && (32'(done_id) < 32'(MAX_REQUESTS))
                    && cur.pending[rid_idx];

    always_comb
    begin
        nxt = cur;
        res = '0;

        unique case (cmd_t'(command))
            CMD_ROUTE:
            begin
                if (full)
                begin
                    res.error = 1'b1;
                end
                else
                begin
                    nxt.pending[rec_idx]   = 1'b1;
                    nxt.total              = total_inc;
                    res.new_request_id     = RID_W'(cur.total);
                    res.request_recorded   = 1'b1;
                    if (cur.phase == PH_CREATING)
                    begin
                        if (!chan_reliable || !persistence_present ||
                            (event_reliable_valid && !event_reliable_value))
                        begin
                            // transient path
                            nxt.safe = 1'b1;
                            if (cur.completed == total_inc)
                            begin
                                nxt.phase        = PH_TERMINAL;
                                res.release_slip = 1'b1;
                            end
                            else
                            begin
                                nxt.phase = PH_TRANSIENT;
                            end
                        end
                        else
                        begin
                            nxt.phase           = PH_NEW;
                            res.enqueue_persist = 1'b1;
                        end
                    end
                end
            end

            CMD_DISPATCH:
            begin
                if (cur.phase == PH_CREATING)
                begin
                    res.error = 1'b1;
                end
                else if (!supplier_shut_down)
                begin
                    if (full)
                    begin
                        res.error = 1'b1;
                    end
                    else
                    begin
                        nxt.pending[rec_idx] = 1'b1;
                        nxt.total            = total_inc;
                        res.new_request_id   = RID_W'(cur.total);
                        res.request_recorded = 1'b1;
                    end
                end
            end

            CMD_COMPLETE:
            begin
                if (!(cur.phase == PH_TRANSIENT || cur.phase == PH_NEW ||
                      cur.phase == PH_SAVING || cur.phase == PH_UPDATING ||
                      cur.phase == PH_SAVED || cur.phase == PH_CWS ||
                      cur.phase == PH_CHANGED) || !rid_ok)
                begin
                    res.error = 1'b1;
                end
                else
                begin
                    nxt.pending[rid_idx] = 1'b0;
                    nxt.completed        = comp_inc;
                    unique case (cur.phase)
                        PH_TRANSIENT:
                        begin
                            if (comp_inc == cur.total)
                            begin
                                nxt.phase        = PH_TERMINAL;
                                res.release_slip = 1'b1;
                            end
                        end
                        PH_NEW:
                        begin
                            if (comp_inc == cur.total)
                            begin
                                nxt.phase = PH_CWN;
                                nxt.safe  = 1'b1;
                            end
                        end
                        PH_SAVING, PH_UPDATING:
                        begin
                            nxt.phase = PH_CWS;
                        end
                        PH_SAVED:
                        begin
                            nxt.phase = (comp_inc == cur.total) ? PH_COMPLETE
                                                                : PH_CHANGED;
                            res.enqueue_persist = 1'b1;
                        end
                        PH_CHANGED:
                        begin
                            if (comp_inc == cur.total)
                                nxt.phase = PH_COMPLETE;
                        end
                        default:
                        begin
                            nxt.phase = cur.phase;
                        end
                    endcase
                end
            end

            CMD_FRONT:
            begin
                unique case (cur.phase)
                    PH_NEW:
                    begin
                        if (cur.has_manager || persistence_present)
                        begin
                            nxt.has_manager = 1'b1;
                            nxt.phase       = PH_SAVING;
                            res.store_start = 1'b1;
                        end
                        else
                        begin
                            // no store: fall back to transient
                            res.queue_done = 1'b1;
                            nxt.safe       = 1'b1;
                            if (cur.completed == cur.total)
                            begin
                                nxt.phase        = PH_TERMINAL;
                                res.release_slip = 1'b1;
                            end
                            else
                            begin
                                nxt.phase = PH_TRANSIENT;
                            end
                        end
                    end
                    PH_CWN:
                    begin
                        res.queue_done   = 1'b1;
                        nxt.phase        = PH_TERMINAL;
                        res.release_slip = 1'b1;
                    end
                    PH_CHANGED:
                    begin
                        nxt.phase        = PH_UPDATING;
                        res.update_start = 1'b1;
                    end
                    PH_COMPLETE:
                    begin
                        nxt.phase        = PH_DELETING;
                        res.remove_start = 1'b1;
                    end
                    default:
                    begin
                        res.error = 1'b1;
                    end
                endcase
            end

            CMD_PERSISTED:
            begin
                unique case (cur.phase)
                    PH_SAVING, PH_UPDATING:
                    begin
                        nxt.phase      = PH_SAVED;
                        nxt.safe       = 1'b1;
                        res.queue_done = 1'b1;
                    end
                    PH_CWS:
                    begin
                        nxt.phase = (cur.completed == cur.total) ? PH_COMPLETE
                                                                 : PH_CHANGED;
                        res.enqueue_persist = 1'b1;
                        nxt.safe            = 1'b1;
                        res.queue_done      = 1'b1;
                    end
                    PH_DELETING:
                    begin
                        nxt.phase        = PH_TERMINAL;
                        res.release_slip = 1'b1;
                        nxt.safe         = 1'b1;
                        res.queue_done   = 1'b1;
                    end
                    default:
                    begin
                        res.error = 1'b1;
                    end
                endcase
            end

            CMD_RECONNECT:
            begin
                nxt.phase = PH_SAVED;
            end

            default:
            begin
                res.error = 1'b1;
            end
        endcase

        res.slip_state  = nxt.phase;
        res.safe        = nxt.safe;
        res.outstanding = OUTS_W'(nxt.total - nxt.completed);
    end

endmodule

`default_nettype wire
